### rtl/ffe_pkg.sv
// ----------------------------------------------------------------------------
// ffe_pkg - shared types and constants of the flat face emitter
// Widths, controller states, datapath operations and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ffe_pkg;

    localparam int COORD_W     = 16;
    localparam int COORD_FRAC  = 14;
    localparam int POS_W       = 26;
    localparam int NORM_W      = 16;
    localparam int IDX_W       = 16;
    localparam int RADIUS_W    = 16;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;
    localparam int RADIUS_FRAC = 8;
    localparam int POS_SHIFT   = COORD_FRAC - RADIUS_FRAC;
    localparam logic [NORM_W-1:0] NORM_ONE = 16'd16384;

    localparam int EDGE_W  = COORD_W + 1;
    localparam int SUM_W   = COORD_W + 2;
    localparam int CROSS_W = 36;
    localparam int DOT_W   = 56;
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int MAG_W      = 24;
    localparam int SQ_W       = 2 * MAG_W + 2;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int LEN_W      = ROOT_STEPS;
    localparam int QUO_W      = 15;
    localparam int REM_W      = LEN_W + 1;
    localparam int NUM_W      = MAG_W + COORD_FRAC + 1;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 144;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] CROSS_LAST  = 5'd5;
    localparam logic [STEP_W-1:0] TRIPLE_LAST = 5'd2;
    localparam logic [STEP_W-1:0] ROOT_LAST   = 5'(ROOT_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST    = 5'(QUO_W - 1);
    localparam logic [1:0]        COMP_LAST   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CROSS,
        ST_DOT,
        ST_PICK,
        ST_SHIFT,
        ST_SQUARE,
        ST_ROOT,
        ST_DIV_LOAD,
        ST_DIV,
        ST_EMIT
    } ffe_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CROSS,
        OP_DOT,
        OP_PICK,
        OP_SHIFT,
        OP_SQUARE,
        OP_ROOT,
        OP_DIV_LOAD,
        OP_DIV,
        OP_EMIT
    } ffe_op_t;

    typedef struct packed {
        ffe_op_t           op;
        logic [STEP_W-1:0] step;
        logic [1:0]        comp;
    } ffe_cmd_t;

    typedef struct packed {
        logic dflt;
        logic big;
        logic out_free;
    } ffe_status_t;

endpackage

### rtl/ffe_ctrl.sv
// ----------------------------------------------------------------------------
// ffe_ctrl - sequencer of the flat face emitter
// Steps the datapath through cross product, flip test, normalisation and the
// emission of three vertices per triangle.
// ----------------------------------------------------------------------------
module ffe_ctrl
    import ffe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ffe_status_t status,
    output ffe_cmd_t    cmd
);

    ffe_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        comp_reg, comp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            comp_reg  <= comp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        comp_next  = comp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                comp_next = '0;
                if (in_valid)
                    state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == CROSS_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_DOT;
                end
            end
            ST_DOT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == TRIPLE_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
                state_next = ST_SHIFT;
            ST_SHIFT:
            begin
                if (status.dflt)
                begin
                    comp_next  = '0;
                    state_next = ST_EMIT;
                end
                else if (!status.big)
                begin
                    step_next  = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == TRIPLE_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == ROOT_LAST)
                begin
                    comp_next  = '0;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD:
            begin
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    if (comp_reg == COMP_LAST)
                    begin
                        comp_next  = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = ST_DIV_LOAD;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    comp_next = comp_reg + 1'b1;
                    if (comp_reg == COMP_LAST)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        cmd.step = step_reg;
        cmd.comp = (state_reg == ST_DOT || state_reg == ST_SQUARE) ? step_reg[1:0] : comp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = OP_LOAD;
            end
            ST_CROSS:    cmd.op = OP_CROSS;
            ST_DOT:      cmd.op = OP_DOT;
            ST_PICK:     cmd.op = OP_PICK;
            ST_SHIFT:    cmd.op = (!status.dflt && status.big) ? OP_SHIFT : OP_NONE;
            ST_SQUARE:   cmd.op = OP_SQUARE;
            ST_ROOT:     cmd.op = OP_ROOT;
            ST_DIV_LOAD: cmd.op = OP_DIV_LOAD;
            ST_DIV:      cmd.op = OP_DIV;
            ST_EMIT:     cmd.op = status.out_free ? OP_EMIT : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

### rtl/ffe_datapath.sv
// ----------------------------------------------------------------------------
// ffe_datapath - arithmetic of the flat face emitter
// Holds the triangle, one shared multiplier, the bit-serial square root and
// divider, the radius register and the output register.
// ----------------------------------------------------------------------------
module ffe_datapath
    import ffe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  cfg_write,
    input  logic [RADIUS_W-1:0]   cfg_data,
    input  ffe_cmd_t              cmd,
    output ffe_status_t           status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_last
);

    logic [RADIUS_W-1:0] radius_reg;

    logic signed [COORD_W-1:0] va_reg [3];
    logic signed [COORD_W-1:0] vb_reg [3];
    logic signed [COORD_W-1:0] vc_reg [3];
    logic signed [EDGE_W-1:0]  e1 [3];
    logic signed [EDGE_W-1:0]  e2 [3];
    logic signed [SUM_W-1:0]   cs [3];

    logic signed [CROSS_W-1:0] cr_reg [3];
    logic signed [DOT_W-1:0]   dot_reg;
    logic                      flip_reg;
    logic                      dflt_reg;
    logic                      sgn_reg [3];
    logic [CROSS_W-1:0]        mag_reg [3];

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic [SQ_W-1:0]  rem_reg;
    logic [SQ_W-1:0]  root_reg;
    logic [SQ_W-1:0]  bit_reg;
    logic [SQ_W-1:0]  root_trial;
    logic [LEN_W-1:0] len;

    logic [NUM_W-1:0]  num;
    logic [REM_W-1:0]  div_rem_reg;
    logic [QUO_W-1:0]  div_low_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [REM_W-1:0]  div_trial;
    logic              div_take;
    logic [QUO_W-1:0]  quo_new;
    logic signed [NORM_W-1:0] norm_reg [3];

    logic                      crnz;
    logic                      csnz;
    logic [CROSS_W-1:0]        cr_abs [3];
    logic signed [COORD_W-1:0] vsel [3];
    logic signed [COORD_W+RADIUS_W:0] scaled [3];
    logic [POS_W-1:0]          pos [3];
    logic [IDX_W-1:0]          index_reg;
    logic                      out_valid_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg;
    logic                      out_last_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            e1[j] = EDGE_W'(vb_reg[j]) - EDGE_W'(va_reg[j]);
            e2[j] = EDGE_W'(vc_reg[j]) - EDGE_W'(va_reg[j]);
            cs[j] = SUM_W'(va_reg[j]) + SUM_W'(vb_reg[j]) + SUM_W'(vc_reg[j]);
            cr_abs[j] = cr_reg[j][CROSS_W-1] ? CROSS_W'(-cr_reg[j]) : CROSS_W'(cr_reg[j]);
        end
        crnz = (cr_reg[0] != '0) || (cr_reg[1] != '0) || (cr_reg[2] != '0);
        csnz = (cs[0] != '0) || (cs[1] != '0) || (cs[2] != '0);
    end

    // shared multiplier: cross terms, dot product and squared magnitudes
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_CROSS:
            begin
                case (cmd.step[2:0])
                    3'd0:    begin mul_a = MUL_A_W'(e1[1]); mul_b = MUL_B_W'(e2[2]); end
                    3'd1:    begin mul_a = MUL_A_W'(e1[2]); mul_b = MUL_B_W'(e2[1]); end
                    3'd2:    begin mul_a = MUL_A_W'(e1[2]); mul_b = MUL_B_W'(e2[0]); end
                    3'd3:    begin mul_a = MUL_A_W'(e1[0]); mul_b = MUL_B_W'(e2[2]); end
                    3'd4:    begin mul_a = MUL_A_W'(e1[0]); mul_b = MUL_B_W'(e2[1]); end
                    default: begin mul_a = MUL_A_W'(e1[1]); mul_b = MUL_B_W'(e2[0]); end
                endcase
            end
            OP_DOT:
            begin
                mul_a = cr_reg[cmd.comp];
                mul_b = MUL_B_W'(cs[cmd.comp]);
            end
            OP_SQUARE:
            begin
                mul_a = $signed(MUL_A_W'(mag_reg[cmd.comp][MAG_W-1:0]));
                mul_b = $signed(MUL_B_W'(mag_reg[cmd.comp][MAG_W-1:0]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // square root and divider step logic
    assign root_trial = root_reg + bit_reg;
    assign len        = (root_reg[LEN_W-1:0] == '0) ? LEN_W'(1) : root_reg[LEN_W-1:0];
    assign num        = {1'b0, mag_reg[cmd.comp][MAG_W-1:0], COORD_FRAC'(0)}
                        + NUM_W'(len >> 1);
    assign div_trial  = {div_rem_reg[REM_W-2:0], div_low_reg[QUO_W-1]};
    assign div_take   = div_trial >= REM_W'(len);
    assign quo_new    = {quo_reg[QUO_W-2:0], div_take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (cfg_write)
            radius_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                for (int j = 0; j < 3; j++)
                begin
                    va_reg[j] <= in_data[COORD_W*j +: COORD_W];
                    vb_reg[j] <= in_data[COORD_W*(j+3) +: COORD_W];
                    vc_reg[j] <= in_data[COORD_W*(j+6) +: COORD_W];
                end
            end
            OP_CROSS:
            begin
                if (cmd.step[0])
                    cr_reg[cmd.step[2:1]] <= cr_reg[cmd.step[2:1]] - CROSS_W'(mul_p);
                else
                    cr_reg[cmd.step[2:1]] <= CROSS_W'(mul_p);
            end
            OP_DOT:
            begin
                if (cmd.comp == 2'd0)
                    dot_reg <= DOT_W'(mul_p);
                else
                    dot_reg <= dot_reg + DOT_W'(mul_p);
            end
            OP_PICK:
            begin
                // zero radius, or zero cross product and zero centroid: fall back to +y
                flip_reg <= (radius_reg != '0) && dot_reg[DOT_W-1];
                dflt_reg <= (radius_reg == '0) || (!crnz && !csnz);
                for (int j = 0; j < 3; j++)
                begin
                    if (crnz)
                    begin
                        mag_reg[j] <= cr_abs[j];
                        sgn_reg[j] <= dot_reg[DOT_W-1] ? (cr_reg[j] > 0) : (cr_reg[j] < 0);
                    end
                    else
                    begin
                        mag_reg[j] <= cs[j][SUM_W-1] ? CROSS_W'(-cs[j]) : CROSS_W'(cs[j]);
                        sgn_reg[j] <= cs[j][SUM_W-1];
                    end
                end
                norm_reg[0] <= '0;
                norm_reg[1] <= NORM_ONE;
                norm_reg[2] <= '0;
            end
            OP_SHIFT:
            begin
                for (int j = 0; j < 3; j++)
                    mag_reg[j] <= mag_reg[j] >> 1;
            end
            OP_SQUARE:
            begin
                if (cmd.comp == 2'd0)
                    rem_reg <= SQ_W'(mul_p);
                else
                    rem_reg <= rem_reg + SQ_W'(mul_p);
                root_reg <= '0;
                bit_reg  <= SQ_W'(1) << (SQ_W - 2);
            end
            OP_ROOT:
            begin
                if (rem_reg >= root_trial)
                begin
                    rem_reg  <= rem_reg - root_trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_DIV_LOAD:
            begin
                div_rem_reg <= REM_W'(num >> QUO_W);
                div_low_reg <= num[QUO_W-1:0];
                quo_reg     <= '0;
            end
            OP_DIV:
            begin
                div_rem_reg <= div_take ? div_trial - REM_W'(len) : div_trial;
                div_low_reg <= div_low_reg << 1;
                quo_reg     <= quo_new;
                if (cmd.step == DIV_LAST)
                    norm_reg[cmd.comp] <= sgn_reg[cmd.comp] ? -$signed(NORM_W'(quo_new))
                                                            : $signed(NORM_W'(quo_new));
            end
            default:
            begin
            end
        endcase
    end

    assign status.dflt = dflt_reg;
    assign status.big  = (mag_reg[0] >> MAG_W != '0) || (mag_reg[1] >> MAG_W != '0)
                         || (mag_reg[2] >> MAG_W != '0);
    assign status.out_free = !out_valid_reg || out_ready;

    // vertex order: A first, then C,B unless the winding was flipped
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            case (cmd.comp)
                2'd0:    vsel[j] = va_reg[j];
                2'd1:    vsel[j] = flip_reg ? vb_reg[j] : vc_reg[j];
                default: vsel[j] = flip_reg ? vc_reg[j] : vb_reg[j];
            endcase
            scaled[j] = vsel[j] * $signed({1'b0, radius_reg})
                        + (COORD_W+RADIUS_W+1)'(1 << (POS_SHIFT - 1));
            pos[j]    = scaled[j][POS_SHIFT +: POS_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            index_reg     <= '0;
        end
        else if (cmd.op == OP_EMIT)
        begin
            out_valid_reg <= 1'b1;
            index_reg     <= index_reg + 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT)
        begin
            out_data_reg <= {2'b00, index_reg, norm_reg[2], norm_reg[1], norm_reg[0],
                             pos[2], pos[1], pos[0]};
            out_last_reg <= (cmd.comp == COMP_LAST);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

### rtl/flat_face_emitter.sv
// ----------------------------------------------------------------------------
// flat_face_emitter - flat shaded triangle emitter for a sphere mesh
// Scales a unit-sphere triangle by the radius and emits its three vertices
// with the shared unit face normal and a running vertex index.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one triangle per item: nine signed Q1.14 coordinates.
//   m_axis returns three items per triangle, the third with tlast high.
//   cfg_valid/cfg_data write the Q8.8 radius; write it only while idle.
// Sequence:
//   From its acceptance to the first vertex a triangle goes through
//   6 cross terms and 3 dot terms in the shared multiplier, the pick,
//   the range check with its shifts, 3 squares, 25 square-root steps
//   and three divisions (load plus 15 steps each) for the normal. The
//   square root and the three divisions make up most of this work.
//   A face with zero cross product and zero centroid, or a zero radius,
//   skips the normalisation and goes from the range check to emission.
//   The three vertices then leave on consecutive cycles while m_axis is
//   ready; the next triangle is taken after the last vertex is emitted.
// Reset:
//   Radius returns to 1.0, the vertex index to zero, the output empties.
// Stalls:
//   The output register holds its item until m_axis_tready; the sequencer
//   waits in its emit phase. A new triangle is taken while the last vertex
//   of the previous one still waits.
// ----------------------------------------------------------------------------
module flat_face_emitter
    import ffe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz (16 bits each)
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x, pos_y, pos_z (26 each), norm_x, norm_y, norm_z (16 each),
    // vertex_index (16), two zero pad bits
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic                  m_axis_tlast,
    input  logic [RADIUS_W-1:0]   cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    ffe_cmd_t    cmd;
    ffe_status_t status;

    // always take radius writes
    assign cfg_ready = 1'b1;

    ffe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ffe_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cfg_write (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

### rtl/ffe_checker.sv
// ----------------------------------------------------------------------------
// ffe_checker - port level checks of the flat face emitter
// Watches the stream ports for stall holding, framing and index order.
// ----------------------------------------------------------------------------
module ffe_checker
    import ffe_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic                  m_axis_tlast
);

    localparam int IDX_LSB = 3 * POS_W + 3 * NORM_W;

    logic [1:0]       phase_reg;
    logic [IDX_W-1:0] expect_idx_reg;
    logic             out_take;

    assign out_take = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            expect_idx_reg <= '0;
        end
        else if (out_take)
        begin
            phase_reg      <= (phase_reg == 2'd2) ? 2'd0 : phase_reg + 1'b1;
            expect_idx_reg <= expect_idx_reg + 1'b1;
        end
    end

    // hold a stalled item
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output item changed");

    // one triangle at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a triangle is in work");

    // tlast on every third vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> (m_axis_tlast == (phase_reg == 2'd2)))
        else $error("tlast out of step with vertex count");

    // indices advance by one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> m_axis_tdata[IDX_LSB +: IDX_W] == expect_idx_reg)
        else $error("vertex index out of sequence");

endmodule

bind flat_face_emitter ffe_checker u_ffe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);

### sim/face_checker.sv
// ----------------------------------------------------------------------------
// face_checker - watches the flat face emitter and checks every vertex
// Predicts the three vertices of each accepted triangle from the radius
// in force, queues them and compares each emitted item, with its tlast, to the next one queued.
// ----------------------------------------------------------------------------
module face_checker
    import ffe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  m_axis_tlast,
    input  logic [RADIUS_W-1:0]   cfg_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic                 last;
        logic [OUT_DATA_W-1:0] data;
    } vertex_t;

    vertex_t         vertex_q[$];
    logic [15:0]     radius_q;
    logic [IDX_W-1:0] next_index;

    function automatic longint scale_coord(longint c, longint r);
        longint p;
        longint q;
        p = c * r + (longint'(1) << (POS_SHIFT - 1));
        if (p >= 0)
            q = p >>> POS_SHIFT;
        else
            q = -(((-p) + (longint'(1) << POS_SHIFT) - 1) >>> POS_SHIFT);
        if (q > 33554431) q = 33554431;
        if (q < -33554432) q = -33554432;
        return q;
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = longint'(1) << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // Unit vector in Q1.14: shift down to 24 bits, floor root, rounded divide.
    task automatic unit_vector(input longint v[3], output longint n[3]);
        longint unsigned mag[3];
        longint unsigned m;
        longint unsigned sq;
        longint unsigned len;
        int s;
        m = 0;
        sq = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        while ((m >> s) >= (64'd1 << 24)) s++;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = mag[i] >> s;
            sq += mag[i] * mag[i];
        end
        len = int_sqrt(sq);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++)
        begin
            n[i] = longint'((mag[i] * 16384 + len / 2) / len);
            if (v[i] < 0) n[i] = -n[i];
        end
    endtask

    task automatic predict_face(input logic [IN_DATA_W-1:0] tri_data);
        longint vt[3][3];
        longint e1[3], e2[3], cr[3], cs[3], dir[3], nrm[3];
        longint dot;
        logic   flip;
        int     order[3];
        vertex_t v;
        flip = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                vt[i][j] = longint'($signed(tri_data[(i*3+j)*16 +: 16]));
        for (int j = 0; j < 3; j++)
        begin
            e1[j] = vt[1][j] - vt[0][j];
            e2[j] = vt[2][j] - vt[0][j];
            cs[j] = vt[0][j] + vt[1][j] + vt[2][j];
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        dir = '{0, 1, 0};
        if (radius_q != 0)
        begin
            dot = cr[0] * cs[0] + cr[1] * cs[1] + cr[2] * cs[2];
            flip = dot < 0;
            if (cr[0] != 0 || cr[1] != 0 || cr[2] != 0)
                for (int j = 0; j < 3; j++) dir[j] = flip ? -cr[j] : cr[j];
            else if (cs[0] != 0 || cs[1] != 0 || cs[2] != 0)
                dir = cs;
        end
        unit_vector(dir, nrm);
        dot = dir[0] * cs[0] + dir[1] * cs[1] + dir[2] * cs[2];
        if (radius_q != 0 && dot < 0)
            for (int j = 0; j < 3; j++) nrm[j] = -nrm[j];
        // the flip and the winding reversal cancel out
        order = '{0, flip ? 1 : 2, flip ? 2 : 1};
        for (int k = 0; k < 3; k++)
        begin
            v.data = '0;
            for (int j = 0; j < 3; j++)
            begin
                v.data[j*POS_W +: POS_W] = POS_W'(scale_coord(vt[order[k]][j], radius_q));
                v.data[3*POS_W + j*NORM_W +: NORM_W] = NORM_W'(nrm[j]);
            end
            v.data[3*POS_W + 3*NORM_W +: IDX_W] = next_index;
            v.last = (k == 2);
            next_index = next_index + 1'b1;
            vertex_q.push_back(v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_q   <= RADIUS_RESET;
            next_index = '0;
            fail_count <= 0;
            pending    <= 0;
            vertex_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                radius_q <= cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                predict_face(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (vertex_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("face_checker: unexpected vertex %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    vertex_t w;
                    w = vertex_q.pop_front();
                    if (w.data !== m_axis_tdata || w.last !== m_axis_tlast)
                    begin
                        if (fail_count < 10)
                            $display("face_checker: mismatch exp %h/%b got %h/%b",
                                     w.data, w.last, m_axis_tdata, m_axis_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= vertex_q.size();
        end
    end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the flat face emitter
// Drives directed and random triangles under several radii with random
// gaps on both channels; the checker beside the block judges each vertex.
// ----------------------------------------------------------------------------
module tb_top;
    import ffe_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  m_axis_tlast;
    logic [RADIUS_W-1:0]   cfg_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    int                    fail_count;
    int                    pending;
    int                    cycle_count;
    logic                  hold_sink;   // long receiver hold-off request

    flat_face_emitter dut (.*);

    face_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run; the slowest correct run is far below this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1000000)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Receiver: random stalls, mostly short, now and then long, plus one
    // long hold-off so the block fills up and stalls its input.
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_sink = 1'b0;
            end
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) gap = 0;
            m_axis_tready <= (gap == 0);
            repeat (gap == 0 ? 1 : gap) @(posedge clk);
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Offer one triangle; hold it until the handshake, then drop valid for
    // a random gap or keep it high if the gap is zero (never lowered and raised in one step).
    task automatic send_triangle(input logic [IN_DATA_W-1:0] t);
        int gap;
        s_axis_tdata  <= t;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 2);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain, let any late work finish, then write the radius while idle.
    task automatic set_radius(input logic [RADIUS_W-1:0] r);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_data  <= r;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 16'sd16384;
            1:       return -16'sd16384;
            2:       return 16'h8000;           // out of range, read as -2.0
            3:       return 16'h7FFF;
            4:       return '0;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_tri(input logic [15:0] c[9]);
        logic [IN_DATA_W-1:0] t;
        for (int i = 0; i < 9; i++) t[i*16 +: 16] = c[i];
        return t;
    endfunction

    // Random face: mostly a genuine triangle, sometimes degenerate.
    function automatic logic [IN_DATA_W-1:0] rand_triangle();
        logic [15:0] c[9];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) c[i] = rand_coord();
        if (kind == 0)
            for (int i = 3; i < 9; i++) c[i] = c[i % 3];           // all equal
        else if (kind == 1)
            for (int i = 0; i < 3; i++) c[6+i] = c[3+i];           // B equals C
        else if (kind == 2)
            for (int i = 0; i < 9; i++) c[i] = 16'($urandom);      // raw noise
        return pack_tri(c);
    endfunction

    initial
    begin
        logic [15:0] c[9];
        logic [RADIUS_W-1:0] radii[4];
        rst_n         = 1'b0;
        cycle_count   = 0;
        hold_sink     = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        cfg_data      = '0;
        cfg_valid     = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset radius, octahedron faces of both windings,
        // degenerate faces (centroid only, and all zero), extreme codes.
        c = '{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384};
        send_triangle(pack_tri(c));
        c = '{16'sd16384, 0, 0, 0, 0, 16'sd16384, 0, 16'sd16384, 0};
        send_triangle(pack_tri(c));
        c = '{16'sd100, 0, 0, 16'sd100, 0, 0, 16'sd100, 0, 0};
        send_triangle(pack_tri(c));
        c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_triangle(pack_tri(c));
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
              16'h8000, 16'h7FFF, 16'h7FFF};
        send_triangle(pack_tri(c));
        c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 16'h8000, 16'h8000, 16'h8000};
        send_triangle(pack_tri(c));
        for (int i = 0; i < 4; i++) send_triangle(rand_triangle());

        // Extremes of the radius, directed faces under each.
        radii = '{16'hFFFF, 16'd0, 16'd1, 16'd256};
        foreach (radii[r])
        begin
            set_radius(radii[r]);
            c = '{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384};
            send_triangle(pack_tri(c));
            c = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                  16'h8000, 16'h7FFF, 16'h7FFF};
            send_triangle(pack_tri(c));
            send_triangle(rand_triangle());
        end

        // Random phases, each under its own radius.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_radius(ph == 5 ? 16'hFFFF : 16'($urandom));
            if (ph == 2) hold_sink = 1'b1;    // long back-pressure in this phase
            for (int n = 0; n < 30; n++)
            begin
                send_triangle(rand_triangle());
                if (ph == 3 && n == 10)
                begin
                    // pause the sender until everything has come back
                    s_axis_tvalid <= 1'b0;
                    @(posedge clk);
                    while (pending != 0) @(posedge clk);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
